// File: sv/tmcs_pkg.sv
// ----------------------------------------------------------------------------
// tmcs_pkg: shared types, widths and the format table for the mip chain sizer
// Holds field widths, the per-cell data record and the block-count helpers.
// ----------------------------------------------------------------------------
package tmcs_pkg;

  localparam int MAX_MIPS   = 15;
  localparam int FMT_W      = 6;
  localparam int DIM_W      = 15;
  localparam int DEPTH_W    = 12;
  localparam int MIP_W      = 4;
  localparam int TOTAL_W    = 44;
  localparam int BYTES_W    = 5;
  localparam int BLK_PROD_W = 2 * DIM_W;
  localparam int BS_W       = BYTES_W + DEPTH_W;
  localparam int LVL_W      = BLK_PROD_W + BS_W;
  localparam int ACC_W      = LVL_W + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic               known;
    logic [BYTES_W-1:0] bytes;
    logic               blk4;
  } fmt_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] sum;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEPTH_W-1:0] d;
    logic [BYTES_W-1:0] bytes;
    logic               blk4;
    logic [MIP_W-1:0]   rem;
    logic               known;
  } cell_data_t;

  function automatic fmt_t fmt_lookup(input logic [FMT_W-1:0] code);
    fmt_t f;
    f = '{known: 1'b0, bytes: '0, blk4: 1'b0};
    unique case (code) inside
      [6'd1:6'd4]:              f = '{known: 1'b1, bytes: 5'd1,  blk4: 1'b0};
      [6'd5:6'd16], 6'd56:      f = '{known: 1'b1, bytes: 5'd2,  blk4: 1'b0};
      [6'd17:6'd31], [6'd57:6'd58]:
                                f = '{known: 1'b1, bytes: 5'd4,  blk4: 1'b0};
      [6'd32:6'd39], 6'd59:     f = '{known: 1'b1, bytes: 5'd8,  blk4: 1'b0};
      [6'd40:6'd42]:            f = '{known: 1'b1, bytes: 5'd12, blk4: 1'b0};
      [6'd43:6'd45]:            f = '{known: 1'b1, bytes: 5'd16, blk4: 1'b0};
      6'd46, [6'd49:6'd50]:     f = '{known: 1'b1, bytes: 5'd8,  blk4: 1'b1};
      [6'd47:6'd48], [6'd51:6'd55]:
                                f = '{known: 1'b1, bytes: 5'd16, blk4: 1'b1};
      default:                  f = '{known: 1'b0, bytes: '0,    blk4: 1'b0};
    endcase
    return f;
  endfunction

  // blocks along one axis: round up by the block edge, floor of one
  function automatic logic [DIM_W-1:0] blk_count(input logic [DIM_W-1:0] dim,
                                                 input logic blk4);
    logic [DIM_W:0]   rnd;
    logic [DIM_W-1:0] n;
    rnd = {1'b0, dim} + (DIM_W+1)'(3);
    n   = blk4 ? DIM_W'(rnd >> 2) : dim;
    return (n == '0) ? DIM_W'(1) : n;
  endfunction

endpackage

// File: sv/tmcs_if.sv
// ----------------------------------------------------------------------------
// tmcs_req_if / tmcs_rsp_if: valid/ready channels of the mip chain sizer
// Request carries one size query, response carries the summed byte count.
// ----------------------------------------------------------------------------
interface tmcs_req_if;
  logic                        valid;
  logic                        ready;
  logic [tmcs_pkg::FMT_W-1:0]   format_code;
  logic [tmcs_pkg::DIM_W-1:0]   width;
  logic [tmcs_pkg::DIM_W-1:0]   height;
  logic [tmcs_pkg::DEPTH_W-1:0] depth;
  logic [tmcs_pkg::MIP_W-1:0]   mip_count;

  modport source (output valid, format_code, width, height, depth, mip_count,
                  input ready);
  modport sink   (input valid, format_code, width, height, depth, mip_count,
                  output ready);
endinterface

interface tmcs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tmcs_pkg::TOTAL_W-1:0] total_bytes;
  logic                        format_known;

  modport source (output valid, total_bytes, format_known, input ready);
  modport sink   (input valid, total_bytes, format_known, output ready);
endinterface

// File: sv/tmcs_cell.sv
// ----------------------------------------------------------------------------
// tmcs_cell: one mip level of the size chain
// Three stages: block counts and products, level size, saturating sum. Hands
// the halved dimensions and the running sum to the next cell.
// ----------------------------------------------------------------------------
module tmcs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tmcs_pkg::cell_data_t data_i,
  output logic                 valid_o,
  output tmcs_pkg::cell_data_t data_o
);

  logic [tmcs_pkg::DIM_W-1:0]      bx, by;
  logic [tmcs_pkg::DEPTH_W-1:0]    slices;
  logic [tmcs_pkg::BLK_PROD_W-1:0] pxy1_d, pxy1_q;
  logic [tmcs_pkg::BS_W-1:0]       bs1_d, bs1_q;
  logic [tmcs_pkg::LVL_W-1:0]      prod2_d, prod2_q;
  logic [tmcs_pkg::ACC_W-1:0]      acc;
  tmcs_pkg::cell_data_t            d1_q, d2_q, d3_d, d3_q;
  logic                            v1_q, v2_q, v3_q;

  always_comb begin
    bx     = tmcs_pkg::blk_count(data_i.w, data_i.blk4);
    by     = tmcs_pkg::blk_count(data_i.h, data_i.blk4);
    slices = (data_i.d == '0) ? tmcs_pkg::DEPTH_W'(1) : data_i.d;
    pxy1_d = tmcs_pkg::BLK_PROD_W'(bx) * tmcs_pkg::BLK_PROD_W'(by);
    bs1_d  = tmcs_pkg::BS_W'(data_i.bytes) * tmcs_pkg::BS_W'(slices);
  end

  assign prod2_d = tmcs_pkg::LVL_W'(pxy1_q) * tmcs_pkg::LVL_W'(bs1_q);

  always_comb begin
    acc  = tmcs_pkg::ACC_W'(d2_q.sum) + tmcs_pkg::ACC_W'(prod2_q);
    d3_d = d2_q;
    if (d2_q.rem != '0) begin
      d3_d.sum = (acc > tmcs_pkg::ACC_W'(tmcs_pkg::TOTAL_MAX)) ? tmcs_pkg::TOTAL_MAX
                                                               : acc[tmcs_pkg::TOTAL_W-1:0];
      d3_d.rem = d2_q.rem - 1'b1;
    end
    d3_d.w = d2_q.w >> 1;
    d3_d.h = d2_q.h >> 1;
    d3_d.d = d2_q.d >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= data_i;
      pxy1_q  <= pxy1_d;
      bs1_q   <= bs1_d;
      d2_q    <= d1_q;
      prod2_q <= prod2_d;
      d3_q    <= d3_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule

// File: sv/texture_mip_chain_size.sv
// ----------------------------------------------------------------------------
// texture_mip_chain_size: byte size of a texture mip chain, one cell per level
// Path: an accepted transaction passes the input register, MAX_MIPS cells of
// three stages each and the output register before its result is valid.
// Throughput: one transaction per cycle while results are taken.
// Reset: asynchronous, active low; clears all valid bits, payload unreset.
// ----------------------------------------------------------------------------
module texture_mip_chain_size (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmcs_req_if.sink   req_i,
  tmcs_rsp_if.source rsp_o
);

  localparam int N = tmcs_pkg::MAX_MIPS;

  logic                             en;
  tmcs_pkg::fmt_t                   fmt;
  tmcs_pkg::cell_data_t             d0_d, d0_q;
  logic                             v0_q;
  logic                 [N:0]       chain_vld;
  tmcs_pkg::cell_data_t             chain_data [N+1];
  logic                             out_valid_q;
  logic [tmcs_pkg::TOTAL_W-1:0]     out_total_q;
  logic                             out_known_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_comb begin
    fmt      = tmcs_pkg::fmt_lookup(req_i.format_code);
    d0_d     = '0;
    d0_d.w   = req_i.width;
    d0_d.h   = req_i.height;
    d0_d.d   = req_i.depth;
    d0_d.bytes = fmt.bytes;
    d0_d.blk4  = fmt.blk4;
    d0_d.known = fmt.known;
    if (fmt.known) begin
      d0_d.rem = (int'(req_i.mip_count) > N) ? tmcs_pkg::MIP_W'(N) : req_i.mip_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q        <= req_i.valid;
      out_valid_q <= chain_vld[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q        <= d0_d;
      out_total_q <= chain_data[N].sum;
      out_known_q <= chain_data[N].known;
    end
  end

  assign chain_vld[0]  = v0_q;
  assign chain_data[0] = d0_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    tmcs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_vld[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_vld[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.total_bytes  = out_total_q;
  assign rsp_o.format_known = out_known_q;

`ifndef SYNTHESIS
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.format_known |-> rsp_o.total_bytes == '0)
    else $error("unknown format gave a nonzero size");

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain_vld))
    else $error("cell chain moved during an output stall");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while result is held");
`endif

endmodule
